[sv/rope_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_pkg
// Shared types and codes for the rotary position embedding block.
// ----------------------------------------------------------------------------
package rope_pkg;

  // Item modes.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ROTATE = 1'b1;

  // Configuration register indexes.
  localparam logic REG_PAIR_COUNT = 1'b0;
  localparam logic REG_SEQ_LEN    = 1'b1;

  localparam int CFG_DATA_W = 9;

  typedef struct packed {
    logic               mode;
    logic [7:0]         position;
    logic [5:0]         pair_index;
    logic signed [15:0] cos_value;
    logic signed [15:0] sin_value;
    logic signed [15:0] x_lo;
    logic signed [15:0] x_hi;
  } item_t;

  typedef struct packed {
    logic signed [15:0] out_lo;
    logic signed [15:0] out_hi;
    logic               saturated;
    logic               status;
  } result_t;

endpackage

[sv/rope_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rope_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16384,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/rotary_position_embedding.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotary position embedding on half-split element pairs, with table storage.
// ----------------------------------------------------------------------------
// The block holds one cosine and one sine entry per (position, pair index) in
// a single synchronous RAM, cosine in the upper half of each word. A load
// transaction (mode 0) writes one entry; a rotate transaction (mode 1) reads
// the entry and returns lo*c - hi*s and lo*s + hi*c, rounded half up, shifted
// right by 14 and saturated to 16 bits. An index at or beyond seq_len,
// pair_count or the table size gives status 1 with zero data, and a load with
// such an index writes nothing. Every transaction, load or rotate, returns
// exactly one result. The block accepts one transaction per clock cycle while
// the output is not stalled. Each transaction passes the RAM read, then the
// four 16x16 multiplies, then the sums, rounding and saturation into the output
// register. The three stages move together, so the pipeline holds while a
// result waits on result_ready and item_ready then drops.
// item_ready also stays low while rst is high. An entry must be loaded before
// it is rotated against; an unwritten entry reads as arbitrary data.
// Configuration is written through cfg_write, cfg_index and cfg_data while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module rotary_position_embedding
  import rope_pkg::*;
#(
  parameter int MAX_POSITIONS = 256,
  parameter int MAX_PAIRS     = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_POSITIONS * MAX_PAIRS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Configuration registers.
  logic [6:0] pair_count;
  logic [8:0] seq_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count <= 7'd64;
      seq_len    <= 9'd256;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAIR_COUNT: pair_count <= cfg_data[6:0];
        REG_SEQ_LEN:    seq_len    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is free or drained.
  logic advance;
  logic accept;
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance && !rst;
  assign accept     = item_valid && item_ready;

  // Range check and table address for the incoming transaction.
  logic              in_range;
  logic [ADDR_W-1:0] addr;
  assign in_range = ({1'b0, item.position} < seq_len) &&
                    (32'(item.position) < MAX_POSITIONS) &&
                    ({1'b0, item.pair_index} < pair_count) &&
                    (32'(item.pair_index) < MAX_PAIRS);
  assign addr = ADDR_W'(32'(item.position) * MAX_PAIRS + 32'(item.pair_index));

  // Writes and reads both happen at the accepting edge, one transaction per
  // edge, so a rotate always sees every load accepted before it without any
  // forwarding path.
  logic        ram_we;
  logic [31:0] ram_rdata;
  assign ram_we = accept && (item.mode == MODE_LOAD) && in_range;

  rope_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({item.cos_value, item.sin_value}),
    .re    (advance),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Stage 1: table read in flight.
  logic               s1_valid;
  logic               s1_rot;
  logic               s1_status;
  logic signed [15:0] s1_x_lo;
  logic signed [15:0] s1_x_hi;

  // Stage 2: products.
  logic               s2_valid;
  logic               s2_rot;
  logic               s2_status;
  logic signed [31:0] s2_lo_c;
  logic signed [31:0] s2_hi_s;
  logic signed [31:0] s2_lo_s;
  logic signed [31:0] s2_hi_c;

  logic signed [15:0] tab_cos;
  logic signed [15:0] tab_sin;
  assign tab_cos = ram_rdata[31:16];
  assign tab_sin = ram_rdata[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      s1_valid     <= item_valid;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  // Rounding and saturation of one sum.
  function automatic logic [16:0] round_sat(input logic signed [33:0] sum);
    logic signed [33:0] biased;
    logic signed [19:0] shifted;
    logic [16:0]        res;
    biased  = sum + 34'sd8192;
    shifted = biased[33:14];
    if (shifted > 20'sd32767) begin
      res = {1'b1, 16'h7fff};
    end else if (shifted < -20'sd32768) begin
      res = {1'b1, 16'h8000};
    end else begin
      res = {1'b0, shifted[15:0]};
    end
    return res;
  endfunction

  logic signed [33:0] sum_lo;
  logic signed [33:0] sum_hi;
  logic [16:0]        rs_lo;
  logic [16:0]        rs_hi;
  assign sum_lo = 34'(s2_lo_c) - 34'(s2_hi_s);
  assign sum_hi = 34'(s2_lo_s) + 34'(s2_hi_c);
  assign rs_lo  = round_sat(sum_lo);
  assign rs_hi  = round_sat(sum_hi);

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_rot    <= (item.mode == MODE_ROTATE) && in_range;
      s1_status <= !in_range;
      s1_x_lo   <= item.x_lo;
      s1_x_hi   <= item.x_hi;

      s2_rot    <= s1_rot;
      s2_status <= s1_status;
      s2_lo_c   <= s1_x_lo * tab_cos;
      s2_hi_s   <= s1_x_hi * tab_sin;
      s2_lo_s   <= s1_x_lo * tab_sin;
      s2_hi_c   <= s1_x_hi * tab_cos;

      // Loads and out-of-range items carry zero data.
      result.status <= s2_status;
      if (s2_rot) begin
        result.out_lo    <= rs_lo[15:0];
        result.out_hi    <= rs_hi[15:0];
        result.saturated <= rs_lo[16] || rs_hi[16];
      end else begin
        result.out_lo    <= '0;
        result.out_hi    <= '0;
        result.saturated <= 1'b0;
      end
    end
  end

endmodule

[sv/rope_checks.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_checks
// Port-level checks for the rotary position embedding block, bound to it.
// ----------------------------------------------------------------------------
module rope_checks
  import rope_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A pending result holds until taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  // Out of reset, the block only refuses transactions while its output is
  // stalled.
  assert property (@(posedge clk) disable iff (rst)
    !rst && !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without output backpressure");

  // A range error carries zero data and no saturation.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |->
      result.out_lo == 16'sd0 && result.out_hi == 16'sd0 && !result.saturated)
    else $error("error result with nonzero data");

  // With the output draining, a result follows once the accepted transaction has passed the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready ##1 result_ready ##1 result_ready |=> result_valid)
    else $error("result missing three cycles after acceptance");

endmodule

bind rotary_position_embedding rope_checks u_rope_checks (.*);

[tb/sv/tb_rotary_position_embedding.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_position_embedding
// Self-checking bench for the rotary position embedding block.
// ----------------------------------------------------------------------------
// Table loads and pair rotations are streamed through the item channel while
// the result channel is drained. A scoreboard keeps its own copy of the
// cosine and sine tables and of the range registers, works out the rotated
// pair for every accepted transaction and compares it field by field with
// the results in order. The run starts with a handful of directed cases and
// then walks through several range settings with random traffic, random idle
// gaps on the item channel and random back-pressure on the result channel.
// ----------------------------------------------------------------------------
module tb_rotary_position_embedding;
  import rope_pkg::*;

  localparam int MAX_POSITIONS = 256;
  localparam int MAX_PAIRS     = 64;
  localparam int TABLE_DEPTH   = MAX_POSITIONS * MAX_PAIRS;
  localparam int STALL_LIMIT   = 1000;

  // Scoreboard: mirrors the table contents and the range registers, and
  // keeps the rotated pairs that are still owed by the block.
  class rotation_checker;
    logic signed [15:0] cos_entry [TABLE_DEPTH];
    logic signed [15:0] sin_entry [TABLE_DEPTH];
    int unsigned        pair_count;
    int unsigned        seq_len;
    result_t            owed_results [$];
    int                 errors;

    function new();
      pair_count = 64;
      seq_len    = 256;
      errors     = 0;
    endfunction

    function void set_reg(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_PAIR_COUNT) pair_count = data[6:0];
      else seq_len = data;
    endfunction

    // Round half up, floor shift by 14, clip to 16 bits.
    function logic [15:0] round_clip(longint sum, inout bit clipped);
      longint v;
      v = (sum + 8192) >>> 14;
      if (v > 32767) begin
        v = 32767;
        clipped = 1'b1;
      end else if (v < -32768) begin
        v = -32768;
        clipped = 1'b1;
      end
      return v[15:0];
    endfunction

    // Applies one transaction to the table copy and returns its result.
    function result_t apply_item(item_t it);
      result_t     r;
      int unsigned addr;
      longint      c, s, lo, hi;
      bit          clipped;
      r = '0;
      clipped = 1'b0;
      if (!(it.position < seq_len && it.position < MAX_POSITIONS &&
            it.pair_index < pair_count && it.pair_index < MAX_PAIRS)) begin
        r.status = 1'b1;
        return r;
      end
      addr = it.position * MAX_PAIRS + it.pair_index;
      if (it.mode == MODE_LOAD) begin
        cos_entry[addr] = it.cos_value;
        sin_entry[addr] = it.sin_value;
        return r;
      end
      c  = longint'($signed(cos_entry[addr]));
      s  = longint'($signed(sin_entry[addr]));
      lo = longint'($signed(it.x_lo));
      hi = longint'($signed(it.x_hi));
      r.out_lo    = round_clip(lo * c - hi * s, clipped);
      r.out_hi    = round_clip(lo * s + hi * c, clipped);
      r.saturated = clipped;
      return r;
    endfunction

    function void note_input(item_t it);
      owed_results.push_back(apply_item(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("result with no transaction waiting for it");
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.out_lo !== want.out_lo) begin
        $error("out_lo mismatch: expected %0d, actual %0d", want.out_lo, got.out_lo);
        errors++;
      end
      if (got.out_hi !== want.out_hi) begin
        $error("out_hi mismatch: expected %0d, actual %0d", want.out_hi, got.out_hi);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0b, actual %0b", want.saturated, got.saturated);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0b, actual %0b", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  item_t                 item;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;
  logic                  cfg_write;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rotation_checker chk;

  // Stimulus-side bookkeeping. A rotation may only read an entry that has
  // been loaded, so every in-range load is remembered here.
  bit          loaded [TABLE_DEPTH];
  int unsigned loaded_list [$];
  int unsigned pos_lim;
  int unsigned pair_lim;
  bit          idle_on;
  bit          stall_on;
  int          quiet_cycles;

  rotary_position_embedding #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .MAX_PAIRS    (MAX_PAIRS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure: random stalls of random length while
  // stall_on is set, otherwise ready stays high.
  initial begin
    result_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  // Monitor. Both channels are sampled at the rising edge, where the values
  // seen are the ones the block registered. The watchdog counts cycles in
  // which neither channel completes a transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) chk.note_input(item);
      if (result_valid && result_ready) chk.check_result(result);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic bit in_range(int unsigned pos, int unsigned pair);
    return pos < pos_lim && pair < pair_lim;
  endfunction

  // Table data is mostly a proper Q1.14 value, with the extremes and the
  // odd raw 16-bit pattern mixed in.
  function automatic logic [15:0] table_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'sd16384;
    if (pick == 1) return -16'sd16384;
    if (pick == 2) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [15:0] element_value();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 16'h8000;
    if (pick == 1) return 16'h7fff;
    return 16'($urandom);
  endfunction

  function automatic item_t pair_item(logic mode, int unsigned pos, int unsigned pair,
                                      logic [15:0] c, logic [15:0] s,
                                      logic [15:0] lo, logic [15:0] hi);
    item_t it;
    it.mode       = mode;
    it.position   = pos[7:0];
    it.pair_index = pair[5:0];
    it.cos_value  = c;
    it.sin_value  = s;
    it.x_lo       = lo;
    it.x_hi       = hi;
    return it;
  endfunction

  // Offers one transaction and returns at the edge where it is taken. Valid
  // is only lowered when an idle gap starts, so a back-to-back transaction
  // never sees valid dropped and raised in the same step.
  task automatic send_item(item_t it);
    int          gap;
    int unsigned addr;
    addr = it.position * MAX_PAIRS + it.pair_index;
    if (in_range(it.position, it.pair_index)) begin
      // Never rotate against an entry that was not loaded.
      if (it.mode == MODE_ROTATE && !loaded[addr]) it.mode = MODE_LOAD;
      if (it.mode == MODE_LOAD && !loaded[addr]) begin
        loaded[addr] = 1'b1;
        loaded_list.push_back(addr);
      end
    end
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Waits until every owed result has come back, then waits out a margin
  // for the three-stage pipeline.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (chk.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both range registers on consecutive edges, pair count first, with the
  // write enable held high across them.
  task automatic write_ranges(logic [CFG_DATA_W-1:0] pairs, logic [CFG_DATA_W-1:0] rows);
    cfg_write <= 1'b1;
    cfg_index <= REG_PAIR_COUNT;
    cfg_data  <= pairs;
    @(posedge clk);
    cfg_index <= REG_SEQ_LEN;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_write <= 1'b0;
    chk.set_reg(REG_PAIR_COUNT, pairs);
    chk.set_reg(REG_SEQ_LEN, rows);
    pair_lim = (pairs[6:0] > MAX_PAIRS) ? MAX_PAIRS : pairs[6:0];
    pos_lim  = (rows > MAX_POSITIONS) ? MAX_POSITIONS : rows;
  endtask

  // Random mix: in-range loads, rotations of loaded entries, out-of-range
  // indexes and a share of unshaped noise.
  task automatic make_random_item(output item_t it);
    int          pick;
    int          t;
    int unsigned addr;
    it = pair_item(1'($urandom), $urandom, $urandom, table_value(), table_value(),
                   element_value(), element_value());
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      if (pos_lim > 0 && pair_lim > 0) begin
        it.mode       = MODE_LOAD;
        it.position   = 8'($urandom_range(0, pos_lim - 1));
        it.pair_index = 6'($urandom_range(0, pair_lim - 1));
      end
    end else if (pick < 75) begin
      it.mode = MODE_ROTATE;
      for (t = 0; t < 8 && loaded_list.size() > 0; t++) begin
        addr          = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        it.position   = 8'(addr / MAX_PAIRS);
        it.pair_index = 6'(addr % MAX_PAIRS);
        if (in_range(it.position, it.pair_index)) break;
      end
    end else if (pick < 88) begin
      if (pos_lim < MAX_POSITIONS && (pair_lim >= MAX_PAIRS || $urandom_range(0, 1) == 1))
        it.position = 8'($urandom_range(pos_lim, MAX_POSITIONS - 1));
      else if (pair_lim < MAX_PAIRS)
        it.pair_index = 6'($urandom_range(pair_lim, MAX_PAIRS - 1));
    end
  endtask

  // Random traffic under the current range settings. Idling is switched on
  // and off in stretches so that some runs stay back-to-back.
  task automatic run_phase(int count, bit allow_idle);
    int    i;
    item_t it;
    for (i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        idle_on  = allow_idle && $urandom_range(0, 2) != 0;
        stall_on = allow_idle && $urandom_range(0, 2) != 0;
      end
      make_random_item(it);
      send_item(it);
    end
    drain();
  endtask

  initial begin
    chk          = new();
    pos_lim      = MAX_POSITIONS;
    pair_lim     = MAX_PAIRS;
    idle_on      = 1'b0;
    stall_on     = 1'b0;
    quiet_cycles = 0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_write  <= 1'b0;
    cfg_index  <= REG_PAIR_COUNT;
    cfg_data   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed cases under the reset range, issued back to back so that a
    // rotation directly follows the load of its own entry.
    // Identity rotation at the first corner with the element extremes.
    send_item(pair_item(MODE_LOAD, 0, 0, 16'sd16384, 16'sd0, 0, 0));
    send_item(pair_item(MODE_ROTATE, 0, 0, 0, 0, 16'h7fff, 16'h8000));
    // Last corner with negative unity entries: out_hi saturates.
    send_item(pair_item(MODE_LOAD, 255, 63, -16'sd16384, -16'sd16384, 0, 0));
    send_item(pair_item(MODE_ROTATE, 255, 63, 0, 0, 16'h8000, 16'h8000));
    // Raw table patterns outside the Q1.14 range are used as given.
    send_item(pair_item(MODE_LOAD, 1, 1, 16'h8000, 16'h7fff, 0, 0));
    send_item(pair_item(MODE_ROTATE, 1, 1, 0, 0, 16'h8000, 16'h7fff));
    send_item(pair_item(MODE_ROTATE, 1, 1, 0, 0, 16'h7fff, 16'h7fff));
    // Exact halves: half up rounds +0.5 to 1 and -0.5 to 0.
    send_item(pair_item(MODE_LOAD, 3, 7, 16'sd8192, -16'sd8192, 0, 0));
    send_item(pair_item(MODE_ROTATE, 3, 7, 0, 0, 16'sd1, 16'sd0));
    send_item(pair_item(MODE_ROTATE, 3, 7, 0, 0, -16'sd1, 16'sd0));
    // Overwrite an entry and read it on the very next cycle.
    send_item(pair_item(MODE_LOAD, 0, 0, 16'sd11585, 16'sd11585, 0, 0));
    send_item(pair_item(MODE_ROTATE, 0, 0, 0, 0, 16'sd4096, -16'sd4096));
    send_item(pair_item(MODE_ROTATE, 255, 63, 0, 0, 16'h7fff, 16'h0001));
    drain();

    // Narrow range: loads outside it write nothing and report status.
    write_ranges(9'd4, 9'd3);
    send_item(pair_item(MODE_LOAD, 3, 0, 16'sd100, 16'sd200, 0, 0));
    send_item(pair_item(MODE_LOAD, 0, 4, 16'sd100, 16'sd200, 0, 0));
    send_item(pair_item(MODE_ROTATE, 3, 7, 0, 0, 16'sd1000, 16'sd1000));
    send_item(pair_item(MODE_ROTATE, 1, 1, 0, 0, 16'sd1000, -16'sd1000));
    send_item(pair_item(MODE_LOAD, 2, 3, 16'sd16384, 16'sd16384, 0, 0));
    send_item(pair_item(MODE_ROTATE, 2, 3, 0, 0, 16'h7fff, 16'h7fff));
    drain();

    // Random traffic over the reset range, then over several settings:
    // smallest, zero, above the table size, random, and full range.
    write_ranges(9'd64, 9'd256);
    run_phase(300, 1'b1);
    write_ranges(9'd1, 9'd1);
    run_phase(100, 1'b1);
    write_ranges(9'd0, 9'd0);
    run_phase(50, 1'b1);
    // Upper data bits beyond the pair_count field are dropped.
    write_ranges(9'h1ff, 9'h1ff);
    run_phase(200, 1'b1);
    write_ranges({2'($urandom), 7'($urandom_range(1, 64))}, 9'($urandom_range(1, 256)));
    run_phase(300, 1'b1);
    write_ranges({2'($urandom), 7'($urandom_range(1, 64))}, 9'($urandom_range(1, 256)));
    run_phase(150, 1'b1);
    // Closing stretch at full range with no idling on either side.
    write_ranges(9'd64, 9'd256);
    run_phase(400, 1'b0);

    repeat (10) @(posedge clk);
    if (chk.errors == 0 && chk.owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (chk.owed_results.size() != 0)
        $error("%0d results never arrived", chk.owed_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
